// File: src/setpoint_ramp_hold_sequencer_top_macros.svh
// assertion macros for the setpoint ramp/hold sequencer
// no dependencies; included by the top level only
`ifndef SETPOINT_RAMP_HOLD_SEQUENCER_TOP_MACROS_SVH
`define SETPOINT_RAMP_HOLD_SEQUENCER_TOP_MACROS_SVH
`ifndef SYNTH
`define SRH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SRH_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SRH_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SRH_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: src/srhs_pkg.sv
// shared types and constants for the setpoint ramp/hold sequencer
// no dependencies
package srhs_pkg;

   typedef enum logic [2:0] {
      ACT_LOAD  = 3'd0,
      ACT_START = 3'd1,
      ACT_STOP  = 3'd2,
      ACT_TICK  = 3'd3,
      ACT_MEAS  = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_RAMP = 2'd1,
      PH_HOLD = 2'd2,
      PH_DONE = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      CSR_MIN_PHASE  = 2'd0,
      CSR_RAMP_UPD   = 2'd1,
      CSR_LOG_PERIOD = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_CUR,
      ST_RD_NEXT,
      ST_EVAL,
      ST_DIV,
      ST_DIV_WAIT,
      ST_OUT
   } ctl_state_type;

   localparam int VW = 17;
   localparam int IW = 16;
   localparam int TW = 24;
   localparam int CW = 16;

   // controller to datapath
   typedef struct packed {
      logic accept;      // capture input transaction
      logic rd_cur;      // read table at current step (step 0 on start)
      logic rd_next;     // read table at the following step
      logic eval;        // apply the transaction
      logic div_start;   // launch interpolation
      logic commit;      // store interpolation result; the last one raises the response
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_div;
      logic div_busy;
   } dp_sts_type;

endpackage

// File: src/srhs_div.sv
// restoring divider, one quotient bit per cycle
// depends on srhs_pkg
module srhs_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [40:0] dividend,
   input  logic [23:0] divisor,
   output logic        busy,
   output logic [40:0] quotient
);
   import srhs_pkg::*;

   logic [40:0] q_ff, q_in;
   logic [24:0] r_ff, r_in;
   logic [23:0] d_ff, d_in;
   logic [5:0]  n_ff, n_in;
   logic        b_ff, b_in;
   logic [24:0] trial;
   logic [25:0] diff;

   // one shift and subtract step
   always_comb begin
      q_in  = q_ff;
      r_in  = r_ff;
      d_in  = d_ff;
      n_in  = n_ff;
      b_in  = b_ff;
      trial = {r_ff[23:0], q_ff[40]};
      diff  = {1'b0, trial} - {2'b00, d_ff};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         n_in = 6'd41;
         b_in = 1'b1;
      end else if (b_ff) begin
         if (!diff[25]) begin
            r_in = diff[24:0];
            q_in = {q_ff[39:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[39:0], 1'b0};
         end
         n_in = n_ff - 6'd1;
         if (n_ff == 6'd1) b_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff <= 1'b0;
         n_ff <= '0;
      end else begin
         b_ff <= b_in;
         n_ff <= n_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign busy     = b_ff;
   assign quotient = q_ff;
endmodule

// File: src/srhs_ctrl.sv
// sequencing controller: handshake and table read / divide ordering
// depends on srhs_pkg
module srhs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output srhs_pkg::dp_cmd_type    cmd,
   input  srhs_pkg::dp_sts_type    sts
);
   import srhs_pkg::*;

   ctl_state_type state_ff, state_in;
   logic div_two_ff, div_two_in;   // second division still to do
   logic rv_ff, rv_in;

   // next state
   always_comb begin
      state_in   = state_ff;
      div_two_in = div_two_ff;
      rv_in      = rv_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         ST_IDLE:     if (req_valid && !rv_ff) state_in = ST_RD_CUR;
         ST_RD_CUR:   state_in = ST_RD_NEXT;
         ST_RD_NEXT:  state_in = ST_EVAL;
         ST_EVAL: begin
            if (sts.need_div) begin
               state_in   = ST_DIV;
               div_two_in = 1'b1;
            end else begin
               state_in = ST_IDLE;
               rv_in    = 1'b1;
            end
         end
         ST_DIV:      state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (!sts.div_busy) state_in = ST_OUT;
         ST_OUT: begin
            if (div_two_ff) begin
               div_two_in = 1'b0;
               state_in   = ST_DIV;
            end else begin
               state_in = ST_IDLE;
               rv_in    = 1'b1;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd           = '0;
      req_ready     = (state_ff == ST_IDLE) && !rv_ff;
      cmd.accept    = req_ready && req_valid;
      cmd.rd_cur    = (state_ff == ST_RD_CUR);
      cmd.rd_next   = (state_ff == ST_RD_NEXT);
      cmd.eval      = (state_ff == ST_EVAL);
      cmd.div_start = (state_ff == ST_DIV);
      cmd.commit    = (state_ff == ST_OUT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_two_ff <= 1'b0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         div_two_ff <= div_two_in;
         rv_ff      <= rv_in;
      end
   end

   assign rsp_valid = rv_ff;
endmodule

// File: src/srhs_dp.sv
// datapath: step table, run state, ramp interpolation and logging
// depends on srhs_pkg and srhs_div
module srhs_dp #(
   parameter int MAX_STEPS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  srhs_pkg::dp_cmd_type     cmd,
   output srhs_pkg::dp_sts_type     sts,
   input  logic                     csr_write_enable,
   input  logic [1:0]               csr_index,
   input  logic [15:0]              csr_write_data,
   input  logic [2:0]               req_action,
   input  logic [5:0]               req_entry_index,
   input  logic [16:0]              req_step_voltage_mv,
   input  logic [15:0]              req_step_current_ma,
   input  logic [23:0]              req_step_hold_ms,
   input  logic [23:0]              req_step_ramp_ms,
   input  logic                     req_step_ramps,
   input  logic [6:0]               req_step_count,
   input  logic [16:0]              req_measured_voltage_mv,
   input  logic [15:0]              req_measured_current_ma,
   output logic [16:0]              rsp_voltage_setpoint_mv,
   output logic [15:0]              rsp_current_setpoint_ma,
   output logic                     rsp_setpoint_update,
   output logic                     rsp_output_on,
   output logic [1:0]               rsp_phase,
   output logic [5:0]               rsp_active_step,
   output logic                     rsp_done_pulse,
   output logic                     rsp_log_point,
   output logic [31:0]              rsp_run_elapsed_ms,
   output logic [16:0]              rsp_logged_voltage_mv,
   output logic [15:0]              rsp_logged_current_ma
);
   import srhs_pkg::*;

   localparam int AW = (MAX_STEPS > 64) ? $clog2(MAX_STEPS) : 6;
   localparam int SW = $clog2(MAX_STEPS + 1);

   typedef struct packed {
      logic [VW-1:0] v;
      logic [IW-1:0] i;
      logic [TW-1:0] hold;
      logic [TW-1:0] ramp;
      logic          flag;
   } entry_type;

   entry_type mem [MAX_STEPS];
   entry_type cur_ff, nxt_ff;

   // configuration registers
   logic [CW-1:0] min_phase_ff, ramp_upd_ff, log_per_ff;
   // captured transaction
   logic [2:0]    act_ff;
   logic [5:0]    idx_ff;
   logic [VW-1:0] sv_ff, mv_ff;
   logic [IW-1:0] si_ff, mi_ff;
   logic [TW-1:0] sh_ff, sr_ff;
   logic          sf_ff;
   logic [6:0]    cnt_ff;
   // run state
   phase_type     ph_ff, ph_in;
   logic [AW-1:0] step_ff, step_in;
   logic [SW-1:0] nsteps_ff, nsteps_in;
   logic [TW-1:0] pt_ff, pt_in;
   logic [31:0]   rt_ff, rt_in;
   logic [VW-1:0] fv_ff, fv_in, setv_ff, setv_in, lv_ff, lv_in;
   logic [IW-1:0] fi_ff, fi_in, seti_ff, seti_in, li_ff, li_in;
   logic          en_ff, en_in;
   logic [CW-1:0] rc_ff, rc_in, lc_ff, lc_in;
   logic          upd_ff, upd_in, done_ff, done_in, logp_ff, logp_in;
   logic          ndiv_in, second_ff;
   logic [TW-1:0] el_ff, el_in;   // elapsed used by the divide

   // read address: entry 0 on start, else current step, then the following step
   logic [AW-1:0] rd_addr;
   always_comb begin
      if (cmd.rd_next) rd_addr = step_ff + AW'(1);
      else if (action_type'(act_ff) == ACT_START) rd_addr = '0;
      else rd_addr = step_ff;
   end

   // step table
   logic [TW-1:0] hold_cl, ramp_cl;
   logic          load_ok;
   always_comb begin
      hold_cl = (sh_ff < TW'(min_phase_ff)) ? TW'(min_phase_ff) : sh_ff;
      ramp_cl = (sr_ff < TW'(min_phase_ff)) ? TW'(min_phase_ff) : sr_ff;
      load_ok = cmd.eval && (action_type'(act_ff) == ACT_LOAD)
                && ({{(AW > 6 ? AW-6 : 1){1'b0}}, idx_ff} < MAX_STEPS);
   end
   always_ff @(posedge clock) begin
      if (load_ok) mem[AW'(idx_ff)] <= '{sv_ff, si_ff, hold_cl, ramp_cl, sf_ff};
      if (cmd.rd_cur) cur_ff <= mem[rd_addr];
      if (cmd.rd_next) nxt_ff <= mem[rd_addr];
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         min_phase_ff <= CW'(500);
         ramp_upd_ff  <= CW'(250);
         log_per_ff   <= CW'(250);
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_PHASE:  min_phase_ff <= csr_write_data;
            CSR_RAMP_UPD:   ramp_upd_ff  <= csr_write_data;
            CSR_LOG_PERIOD: log_per_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // capture
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         act_ff <= req_action;
         idx_ff <= req_entry_index;
         sv_ff  <= req_step_voltage_mv;
         si_ff  <= req_step_current_ma;
         sh_ff  <= req_step_hold_ms;
         sr_ff  <= req_step_ramp_ms;
         sf_ff  <= req_step_ramps;
         cnt_ff <= req_step_count;
         mv_ff  <= req_measured_voltage_mv;
         mi_ff  <= req_measured_current_ma;
      end
   end

   // interpolation divide
   logic          div_busy;
   logic [40:0]   quot;
   logic          up_dir;
   logic [VW-1:0] span_v, tgt_v, frm_v;
   logic [40:0]   prod;
   always_comb begin
      tgt_v  = second_ff ? VW'(cur_ff.i) : cur_ff.v;
      frm_v  = second_ff ? VW'(fi_ff) : fv_ff;
      up_dir = tgt_v >= frm_v;
      span_v = up_dir ? tgt_v - frm_v : frm_v - tgt_v;
      prod   = span_v * el_ff;
   end
   logic [40:0]   prod_ff;
   logic          prod_go;
   always_ff @(posedge clock) begin
      prod_ff <= prod;
      if (reset) prod_go <= 1'b0;
      else prod_go <= cmd.div_start;
   end
   srhs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (prod_go),
      .dividend (prod_ff),
      .divisor  (cur_ff.ramp),
      .busy     (div_busy),
      .quotient (quot)
   );
   assign sts.div_busy  = div_busy || cmd.div_start || prod_go;
   assign sts.need_div  = ndiv_in;

   // transaction evaluation
   logic [SW-1:0] n_cl;
   logic [TW-1:0] pt_inc;
   logic [CW-1:0] lc_inc, rc_inc;
   logic [SW:0]   next_step;
   always_comb begin
      ph_in = ph_ff; step_in = step_ff; nsteps_in = nsteps_ff; pt_in = pt_ff;
      rt_in = rt_ff; fv_in = fv_ff; fi_in = fi_ff; setv_in = setv_ff;
      seti_in = seti_ff; lv_in = lv_ff; li_in = li_ff; en_in = en_ff;
      rc_in = rc_ff; lc_in = lc_ff; upd_in = upd_ff; done_in = done_ff;
      logp_in = logp_ff; ndiv_in = 1'b0; el_in = el_ff;
      n_cl      = (cnt_ff > 7'(MAX_STEPS > 127 ? 127 : MAX_STEPS))
                  ? SW'(MAX_STEPS) : SW'(cnt_ff);
      pt_inc    = pt_ff + TW'(1);
      lc_inc    = lc_ff + CW'(1);
      rc_inc    = rc_ff + CW'(1);
      next_step = {1'b0, SW'(step_ff)} + (SW+1)'(1);
      if (cmd.eval) begin
         upd_in = 1'b0; done_in = 1'b0; logp_in = 1'b0;
         case (action_type'(act_ff))
            ACT_START: begin
               if (cnt_ff != 7'd0) begin
                  nsteps_in = n_cl; step_in = '0; rt_in = '0; lc_in = '0;
                  lv_in = '0; li_in = '0; en_in = 1'b1; pt_in = '0;
                  setv_in = cur_ff.v; seti_in = cur_ff.i; ph_in = PH_HOLD;
                  upd_in = 1'b1;
               end
            end
            ACT_STOP: begin
               if (ph_ff != PH_IDLE) begin
                  en_in = 1'b0; ph_in = PH_IDLE;
               end
            end
            ACT_TICK: begin
               if (ph_ff == PH_RAMP || ph_ff == PH_HOLD) begin
                  if (rt_ff != '1) rt_in = rt_ff + 32'd1;
                  lc_in = lc_inc;
                  if (lc_inc >= log_per_ff) begin
                     logp_in = 1'b1; lc_in = '0;
                  end
                  pt_in = pt_inc;
                  if (ph_ff == PH_RAMP) begin
                     if (pt_inc >= cur_ff.ramp) begin
                        setv_in = cur_ff.v; seti_in = cur_ff.i; upd_in = 1'b1;
                        ph_in = PH_HOLD; pt_in = '0;
                     end else begin
                        rc_in = rc_inc;
                        if (rc_inc >= ramp_upd_ff) begin
                           rc_in = '0; upd_in = 1'b1; ndiv_in = 1'b1;
                           el_in = pt_inc;
                        end
                     end
                  end else if (pt_inc >= cur_ff.hold) begin
                     if (next_step >= {1'b0, nsteps_ff}) begin
                        en_in = 1'b0; ph_in = PH_DONE; done_in = 1'b1;
                     end else begin
                        step_in = AW'(next_step);
                        pt_in = '0;
                        // enter the following step from the entry read ahead
                        if (nxt_ff.flag) begin
                           fv_in = cur_ff.v; fi_in = cur_ff.i; rc_in = '0;
                           ph_in = PH_RAMP;
                        end else begin
                           setv_in = nxt_ff.v; seti_in = nxt_ff.i; upd_in = 1'b1;
                           ph_in = PH_HOLD;
                        end
                     end
                  end
               end
            end
            ACT_MEAS: begin
               lv_in = mv_ff; li_in = mi_ff;
            end
            default: ;
         endcase
      end
      // interpolation result, voltage on the first pass, current on the second
      if (cmd.commit) begin
         if (!second_ff)
            setv_in = up_dir ? frm_v + VW'(quot) : frm_v - VW'(quot);
         else
            seti_in = up_dir ? IW'(frm_v + VW'(quot)) : IW'(frm_v - VW'(quot));
      end
   end

   // run state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE; step_ff <= '0; nsteps_ff <= '0; pt_ff <= '0;
         rt_ff <= '0; fv_ff <= '0; fi_ff <= '0; setv_ff <= '0; seti_ff <= '0;
         lv_ff <= '0; li_ff <= '0; en_ff <= 1'b0; rc_ff <= '0; lc_ff <= '0;
         upd_ff <= 1'b0; done_ff <= 1'b0; logp_ff <= 1'b0; second_ff <= 1'b0;
         el_ff <= '0;
      end else begin
         ph_ff <= ph_in; step_ff <= step_in; nsteps_ff <= nsteps_in;
         pt_ff <= pt_in; rt_ff <= rt_in; fv_ff <= fv_in; fi_ff <= fi_in;
         setv_ff <= setv_in; seti_ff <= seti_in; lv_ff <= lv_in; li_ff <= li_in;
         en_ff <= en_in; rc_ff <= rc_in; lc_ff <= lc_in; upd_ff <= upd_in;
         done_ff <= done_in; logp_ff <= logp_in;
         el_ff <= el_in;
         if (cmd.commit) second_ff <= !second_ff;
      end
   end

   // response fields
   assign rsp_voltage_setpoint_mv = setv_ff;
   assign rsp_current_setpoint_ma = seti_ff;
   assign rsp_setpoint_update     = upd_ff;
   assign rsp_output_on           = en_ff;
   assign rsp_phase               = ph_ff;
   assign rsp_active_step         = 6'(step_ff);
   assign rsp_done_pulse          = done_ff;
   assign rsp_log_point           = logp_ff;
   assign rsp_run_elapsed_ms      = rt_ff;
   assign rsp_logged_voltage_mv   = lv_ff;
   assign rsp_logged_current_ma   = li_ff;
endmodule

// File: src/setpoint_ramp_hold_sequencer_top.sv
// top level of the setpoint ramp/hold sequencer
// depends on srhs_pkg, srhs_ctrl, srhs_dp and the macros header
//
// channel | ports        | direction
// req     | req_valid    | in
// rsp     | rsp_valid    | out
// csr     | csr_write_*  | in
//
// a transaction runs from accept through reads of the current and the
// following table entries and evaluation to the response; a ramp update
// adds two divide passes, voltage then current, each through the 41-step
// bit-serial divider
// reset is synchronous; the step table is not cleared
// the response is held until rsp_ready; no new transaction meanwhile
`include "setpoint_ramp_hold_sequencer_top_macros.svh"
module setpoint_ramp_hold_sequencer_top #(
   parameter int MAX_STEPS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [5:0]  req_entry_index,
   input  logic [16:0] req_step_voltage_mv,
   input  logic [15:0] req_step_current_ma,
   input  logic [23:0] req_step_hold_ms,
   input  logic [23:0] req_step_ramp_ms,
   input  logic        req_step_ramps,
   input  logic [6:0]  req_step_count,
   input  logic [16:0] req_measured_voltage_mv,
   input  logic [15:0] req_measured_current_ma,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [16:0] rsp_voltage_setpoint_mv,
   output logic [15:0] rsp_current_setpoint_ma,
   output logic        rsp_setpoint_update,
   output logic        rsp_output_on,
   output logic [1:0]  rsp_phase,
   output logic [5:0]  rsp_active_step,
   output logic        rsp_done_pulse,
   output logic        rsp_log_point,
   output logic [31:0] rsp_run_elapsed_ms,
   output logic [16:0] rsp_logged_voltage_mv,
   output logic [15:0] rsp_logged_current_ma
);
   import srhs_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // controller
   srhs_ctrl u_ctrl (
      .clock (clock), .reset (reset),
      .req_valid (req_valid), .req_ready (req_ready),
      .rsp_valid (rsp_valid), .rsp_ready (rsp_ready),
      .cmd (cmd), .sts (sts)
   );

   // datapath
   srhs_dp #(.MAX_STEPS(MAX_STEPS)) u_dp (
      .clock (clock), .reset (reset), .cmd (cmd), .sts (sts),
      .csr_write_enable (csr_write_enable), .csr_index (csr_index),
      .csr_write_data (csr_write_data),
      .req_action (req_action), .req_entry_index (req_entry_index),
      .req_step_voltage_mv (req_step_voltage_mv),
      .req_step_current_ma (req_step_current_ma),
      .req_step_hold_ms (req_step_hold_ms), .req_step_ramp_ms (req_step_ramp_ms),
      .req_step_ramps (req_step_ramps), .req_step_count (req_step_count),
      .req_measured_voltage_mv (req_measured_voltage_mv),
      .req_measured_current_ma (req_measured_current_ma),
      .rsp_voltage_setpoint_mv (rsp_voltage_setpoint_mv),
      .rsp_current_setpoint_ma (rsp_current_setpoint_ma),
      .rsp_setpoint_update (rsp_setpoint_update), .rsp_output_on (rsp_output_on),
      .rsp_phase (rsp_phase), .rsp_active_step (rsp_active_step),
      .rsp_done_pulse (rsp_done_pulse), .rsp_log_point (rsp_log_point),
      .rsp_run_elapsed_ms (rsp_run_elapsed_ms),
      .rsp_logged_voltage_mv (rsp_logged_voltage_mv),
      .rsp_logged_current_ma (rsp_logged_current_ma)
   );

   // checks
   `SRH_ASSERT_IMP(a_no_accept_busy, clock, reset, rsp_valid, !req_ready, "accept while response pending")
   `SRH_ASSERT_IMP(a_idle_off, clock, reset, rsp_valid && rsp_phase == PH_IDLE && !rsp_output_on, !rsp_done_pulse, "done pulse while idle")
   `SRH_ASSERT_NXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready, "ready right after accept")
endmodule
